// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file mds_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define MDS_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define MDS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/mds_pkg.sv =====
// types, codes and reset constants of the motor direction and speed dither block
// no dependencies
package mds_pkg;

    localparam int SPEED_BITS_DEF = 16;
    localparam int TIMER_BITS_DEF = 10;

    localparam int TARGET_W   = 15;
    localparam int SWING_W    = 15;
    localparam int INTERVAL_W = 10;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_SPEED_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SWING  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 2'd2;

    localparam logic [TARGET_W-1:0]   TARGET_RST   = 15'd1000;
    localparam logic [SWING_W-1:0]    SWING_RST    = 15'd100;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 10'd200;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MIN = 10'd100;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = 10'd1000;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_RIGHT = 2'd1,
        MODE_LEFT  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [TARGET_W-1:0]   speed_target;
        logic [SWING_W-1:0]    speed_swing;
        logic [INTERVAL_W-1:0] step_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic switch_right;
        logic switch_left;
        logic remote_right;
        logic remote_left;
        logic remote_stop;
    } t_req;

    typedef struct packed {
        t_mode                  motor_mode;
        logic [OUT_SPEED_W-1:0] drive_speed;
        logic                   speed_write;
        logic                   direction_write;
        logic [1:0]             direction_code;
    } t_res;

endpackage

// ===== rtl/core/mds_intf.sv =====
// channel interfaces: command tick, result and configuration write
// depends on mds_pkg
interface mds_cmd_if;
    logic valid;
    logic ready;
    logic switch_right;
    logic switch_left;
    logic remote_right;
    logic remote_left;
    logic remote_stop;

    modport source (output valid, switch_right, switch_left, remote_right, remote_left,
                    remote_stop, input ready);
    modport sink (input valid, switch_right, switch_left, remote_right, remote_left,
                  remote_stop, output ready);
endinterface

interface mds_res_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     motor_mode;
    logic [mds_pkg::OUT_SPEED_W-1:0] drive_speed;
    logic                           speed_write;
    logic                           direction_write;
    logic [1:0]                     direction_code;

    modport source (output valid, motor_mode, drive_speed, speed_write, direction_write,
                    direction_code, input ready);
    modport sink (input valid, motor_mode, drive_speed, speed_write, direction_write,
                  direction_code, output ready);
endinterface

interface mds_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mds_pkg::CFG_IDX_W-1:0]  index;
    logic [mds_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/mds_cfg_regs.sv =====
// configuration registers with interval clamping
// depends on mds_pkg and mds_intf
module mds_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mds_cfg_if.sink           i_cfg,
    output mds_pkg::t_cfg     o_cfg
);

    mds_pkg::t_cfg                      r_cfg;
    logic [mds_pkg::INTERVAL_W-1:0]     wr_interval;
    logic [mds_pkg::INTERVAL_W-1:0]     clamped;
    logic                               wr_en;

    assign i_cfg.ready = 1'b1;
    assign wr_en       = i_cfg.valid;
    assign wr_interval = i_cfg.data[mds_pkg::INTERVAL_W-1:0];

    always_comb begin
        clamped = wr_interval;
        if (wr_interval < mds_pkg::INTERVAL_MIN) begin
            clamped = mds_pkg::INTERVAL_MIN;
        end else if (wr_interval > mds_pkg::INTERVAL_MAX) begin
            clamped = mds_pkg::INTERVAL_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_target     <= mds_pkg::TARGET_RST;
            r_cfg.speed_swing      <= mds_pkg::SWING_RST;
            r_cfg.step_interval_ms <= mds_pkg::INTERVAL_RST;
        end else if (wr_en) begin
            case (i_cfg.index)
                mds_pkg::REG_SPEED_TARGET: begin
                    r_cfg.speed_target <= i_cfg.data[mds_pkg::TARGET_W-1:0];
                end
                mds_pkg::REG_SPEED_SWING: begin
                    r_cfg.speed_swing <= i_cfg.data[mds_pkg::SWING_W-1:0];
                end
                mds_pkg::REG_STEP_INTERVAL: begin
                    r_cfg.step_interval_ms <= clamped;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/mds_engine.sv =====
// mode state machine, interval timer and speed dither step
// depends on mds_pkg
module mds_engine #(
    parameter int SPEED_BITS = mds_pkg::SPEED_BITS_DEF,
    parameter int TIMER_BITS = mds_pkg::TIMER_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mds_pkg::t_cfg i_cfg,
    input  logic          i_fire,
    input  mds_pkg::t_req i_req,
    output mds_pkg::t_res o_res
);

    localparam int WIDE = ((SPEED_BITS > mds_pkg::OUT_SPEED_W) ?
                           SPEED_BITS : mds_pkg::OUT_SPEED_W) + 1;
    localparam logic [WIDE-1:0] SPEED_CAP = (WIDE'(1) << SPEED_BITS) - WIDE'(1);
    localparam logic [TIMER_BITS-1:0] TIMER_CAP = {TIMER_BITS{1'b1}};

    mds_pkg::t_mode          r_mode;
    mds_pkg::t_mode          n_mode;
    logic [SPEED_BITS-1:0]   r_speed;
    logic [SPEED_BITS-1:0]   n_speed;
    logic                    r_rise;
    logic                    n_rise;
    logic [TIMER_BITS-1:0]   r_cnt;
    logic [TIMER_BITS-1:0]   n_cnt;

    logic                    changed;
    logic                    step_tick;
    logic [TIMER_BITS-1:0]   cnt_a;
    logic [SPEED_BITS-1:0]   spd_a;
    logic [WIDE-1:0]         spd_w;
    logic [WIDE-1:0]         step_w;
    logic [WIDE-1:0]         hi;
    logic [WIDE-1:0]         lo;
    logic [WIDE-1:0]         up_s;
    logic [WIDE-1:0]         dn_s;
    logic [WIDE-1:0]         out_ext;

    function automatic logic [WIDE-1:0] cap_speed(input logic [WIDE-1:0] v);
        return (v > SPEED_CAP) ? SPEED_CAP : v;
    endfunction

    // next mode from the tick's request levels
    always_comb begin
        n_mode = mds_pkg::MODE_IDLE;
        if (i_req.remote_stop) begin
            n_mode = mds_pkg::MODE_IDLE;
        end else if ((i_req.switch_right && i_req.switch_left) ||
                     (i_req.remote_right && i_req.remote_left)) begin
            n_mode = mds_pkg::MODE_IDLE;
        end else if (i_req.switch_right || i_req.remote_right) begin
            n_mode = mds_pkg::MODE_RIGHT;
        end else if (i_req.switch_left || i_req.remote_left) begin
            n_mode = mds_pkg::MODE_LEFT;
        end
    end

    // timer, reload and dither step
    always_comb begin
        changed = (n_mode != r_mode);
        cnt_a   = (r_cnt == TIMER_CAP) ? r_cnt : r_cnt + 1'b1;
        spd_a   = r_speed;
        if (changed) begin
            cnt_a = '0;
            spd_a = (n_mode == mds_pkg::MODE_IDLE) ? '0 :
                    SPEED_BITS'(cap_speed(WIDE'(i_cfg.speed_target)));
        end

        step_tick = (n_mode != mds_pkg::MODE_IDLE) &&
                    (cnt_a >= TIMER_BITS'(i_cfg.step_interval_ms));

        spd_w  = WIDE'(spd_a);
        step_w = WIDE'(i_cfg.speed_swing >> 1);
        hi     = cap_speed(WIDE'(i_cfg.speed_target) + WIDE'(i_cfg.speed_swing));
        lo     = cap_speed((i_cfg.speed_target > i_cfg.speed_swing) ?
                           WIDE'(i_cfg.speed_target) - WIDE'(i_cfg.speed_swing) : '0);
        up_s   = spd_w + step_w;
        dn_s   = (spd_w > step_w) ? spd_w - step_w : '0;

        n_cnt   = cnt_a;
        n_speed = spd_a;
        n_rise  = r_rise;
        if (step_tick) begin
            n_cnt = '0;
            if (r_rise) begin
                if (up_s >= hi) begin
                    n_speed = SPEED_BITS'(hi);
                    n_rise  = 1'b0;
                end else begin
                    n_speed = SPEED_BITS'(cap_speed(up_s));
                end
            end else begin
                if (dn_s <= lo) begin
                    n_speed = SPEED_BITS'(lo);
                    n_rise  = 1'b1;
                end else begin
                    n_speed = SPEED_BITS'(dn_s);
                end
            end
        end
    end

    // result of this tick
    always_comb begin
        out_ext               = WIDE'(n_speed);
        o_res.motor_mode      = n_mode;
        o_res.direction_code  = n_mode;
        o_res.direction_write = step_tick;
        o_res.speed_write     = step_tick || (n_mode == mds_pkg::MODE_IDLE);
        o_res.drive_speed     = (n_mode == mds_pkg::MODE_IDLE) ? '0 :
                                out_ext[mds_pkg::OUT_SPEED_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= mds_pkg::MODE_IDLE;
            r_speed <= '0;
            r_rise  <= 1'b1;
            r_cnt   <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_speed <= n_speed;
            r_rise  <= n_rise;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/motor_direction_speed_dither.sv =====
// motor direction and speed dither: top level with input and result registers
// an accepted transaction goes through the input register, the engine and the result register to o_res
// throughput: one transaction per cycle while o_res is not stalled, set by the combinational mode and step logic
// reset: synchronous, clears to idle, speed 0, ramping up, timer 0, registers to defaults
// depends on mds_pkg, mds_intf, mds_cfg_regs and mds_engine
module motor_direction_speed_dither #(
    parameter int SPEED_BITS = mds_pkg::SPEED_BITS_DEF,
    parameter int TIMER_BITS = mds_pkg::TIMER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mds_cmd_if.sink     i_cmd,
    mds_cfg_if.sink     i_cfg,
    mds_res_if.source   o_res
);

    mds_pkg::t_cfg cfg;
    mds_pkg::t_req r_req;
    mds_pkg::t_res eng_res;
    mds_pkg::t_res r_res;
    logic          r_in_valid;
    logic          r_out_valid;
    logic          advance;
    logic          take;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || advance;
    assign take        = i_cmd.valid && i_cmd.ready;

    mds_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    mds_engine #(
        .SPEED_BITS (SPEED_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (advance),
        .i_req   (r_req),
        .o_res   (eng_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req.switch_right <= i_cmd.switch_right;
            r_req.switch_left  <= i_cmd.switch_left;
            r_req.remote_right <= i_cmd.remote_right;
            r_req.remote_left  <= i_cmd.remote_left;
            r_req.remote_stop  <= i_cmd.remote_stop;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= eng_res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.motor_mode      = r_res.motor_mode;
    assign o_res.drive_speed     = r_res.drive_speed;
    assign o_res.speed_write     = r_res.speed_write;
    assign o_res.direction_write = r_res.direction_write;
    assign o_res.direction_code  = r_res.direction_code;

endmodule

// ===== rtl/core/mds_checker.sv =====
// port-level checks of the result channel, bound to the top level
// depends on mds_pkg and assert_macros.svh
`include "assert_macros.svh"

module mds_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_res_valid,
    input logic                            i_res_ready,
    input logic [1:0]                      i_motor_mode,
    input logic [mds_pkg::OUT_SPEED_W-1:0] i_drive_speed,
    input logic                            i_speed_write,
    input logic                            i_direction_write,
    input logic [1:0]                      i_direction_code
);

    // idle transactions always write a zero speed
    `MDS_ASSERT(a_idle_zero, i_clk, i_rst_n, !(i_res_valid && (i_motor_mode == mds_pkg::MODE_IDLE)) || (i_drive_speed == '0 && i_speed_write && !i_direction_write))

    // direction code follows the mode
    `MDS_ASSERT(a_dir_code, i_clk, i_rst_n, !i_res_valid || (i_direction_code == i_motor_mode))

    // a direction write always comes with a speed write
    `MDS_ASSERT(a_dir_with_speed, i_clk, i_rst_n, !(i_res_valid && i_direction_write) || i_speed_write)

    // stalled result stays offered
    `MDS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid)

endmodule

bind motor_direction_speed_dither mds_checker u_mds_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_motor_mode      (o_res.motor_mode),
    .i_drive_speed     (o_res.drive_speed),
    .i_speed_write     (o_res.speed_write),
    .i_direction_write (o_res.direction_write),
    .i_direction_code  (o_res.direction_code)
);

// ===== bench/tb_motor_direction_speed_dither.sv =====
// self-checking bench for motor_direction_speed_dither: millisecond ticks in, drive results out
// predicts mode, dither speed and register writes per tick and compares every result
// depends on mds_pkg, mds_intf and the motor_direction_speed_dither rtl
module tb_motor_direction_speed_dither;

    localparam int unsigned SPEED_MAX   = (1 << mds_pkg::SPEED_BITS_DEF) - 1;
    localparam int unsigned TIMER_MAX   = (1 << mds_pkg::TIMER_BITS_DEF) - 1;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          HOLD_LEN    = 120;
    localparam int          TAIL_CYCLES = 10;
    localparam logic [mds_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mds_cmd_if cmd_ch ();
    mds_cfg_if cfg_ch ();
    mds_res_if res_ch ();

    motor_direction_speed_dither dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    always #10 i_clk = ~i_clk;

    // predictor state and register copies
    mds_pkg::t_mode mode_now = mds_pkg::MODE_IDLE;
    int unsigned    speed_now = 0;
    logic           ramp_up = 1'b1;
    int unsigned    tick_count = 0;
    int unsigned    reg_target = mds_pkg::TARGET_RST;
    int unsigned    reg_swing = mds_pkg::SWING_RST;
    int unsigned    reg_interval = mds_pkg::INTERVAL_RST;

    mds_pkg::t_req pending_ticks[$];
    mds_pkg::t_res drive_results_due[$];

    int unsigned ticks_queued = 0;
    int unsigned ticks_taken = 0;
    int unsigned results_seen = 0;
    int unsigned speed_steps = 0;
    int unsigned reg_writes = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_armed = 1'b0;
    int   hold_count = 0;

    mds_pkg::t_req next_req;
    mds_pkg::t_req taken_req;
    mds_pkg::t_res due_res;
    mds_pkg::t_res seen_res;
    string         bad_fields;

    function automatic mds_pkg::t_mode requested_mode(mds_pkg::t_req r);
        if (r.remote_stop) return mds_pkg::MODE_IDLE;
        if ((r.switch_right && r.switch_left) || (r.remote_right && r.remote_left))
            return mds_pkg::MODE_IDLE;
        if (r.switch_right || r.remote_right) return mds_pkg::MODE_RIGHT;
        if (r.switch_left || r.remote_left) return mds_pkg::MODE_LEFT;
        return mds_pkg::MODE_IDLE;
    endfunction

    function automatic mds_pkg::t_res drive_step(mds_pkg::t_req r);
        mds_pkg::t_mode want;
        int unsigned    hi;
        int unsigned    lo;
        int unsigned    half;
        int unsigned    s;
        mds_pkg::t_res  res;
        want = requested_mode(r);
        if (tick_count < TIMER_MAX) tick_count++;
        if (want != mode_now) begin
            mode_now = want;
            speed_now = (want == mds_pkg::MODE_IDLE) ? 0 : reg_target;
            tick_count = 0;
        end
        res.speed_write = 1'b0;
        res.direction_write = 1'b0;
        if (mode_now == mds_pkg::MODE_IDLE) begin
            res.speed_write = 1'b1;
        end else if (tick_count >= reg_interval) begin
            hi = reg_target + reg_swing;
            if (hi > SPEED_MAX) hi = SPEED_MAX;
            lo = (reg_target > reg_swing) ? reg_target - reg_swing : 0;
            half = reg_swing >> 1;
            tick_count = 0;
            if (ramp_up) begin
                s = speed_now + half;
                if (s >= hi) begin
                    s = hi;
                    ramp_up = 1'b0;
                end
            end else begin
                s = (speed_now > half) ? speed_now - half : 0;
                if (s <= lo) begin
                    s = lo;
                    ramp_up = 1'b1;
                end
            end
            speed_now = s;
            res.speed_write = 1'b1;
            res.direction_write = 1'b1;
        end
        res.motor_mode = mode_now;
        res.drive_speed = (mode_now == mds_pkg::MODE_IDLE) ? '0 :
                          speed_now[mds_pkg::OUT_SPEED_W-1:0];
        res.direction_code = mode_now;
        return res;
    endfunction

    // driver: one transaction per pending tick, random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                taken_req = {cmd_ch.switch_right, cmd_ch.switch_left, cmd_ch.remote_right,
                             cmd_ch.remote_left, cmd_ch.remote_stop};
                due_res = drive_step(taken_req);
                if (due_res.direction_write) speed_steps++;
                drive_results_due.push_back(due_res);
                ticks_taken++;
            end
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = pending_ticks.pop_front();
                    cmd_ch.valid <= 1'b1;
                    cmd_ch.switch_right <= next_req.switch_right;
                    cmd_ch.switch_left <= next_req.switch_left;
                    cmd_ch.remote_right <= next_req.remote_right;
                    cmd_ch.remote_left <= next_req.remote_left;
                    cmd_ch.remote_stop <= next_req.remote_stop;
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_armed && hold_count < HOLD_LEN) hold_count <= hold_count + 1;
    end

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                seen_res.motor_mode = mds_pkg::t_mode'(res_ch.motor_mode);
                seen_res.drive_speed = res_ch.drive_speed;
                seen_res.speed_write = res_ch.speed_write;
                seen_res.direction_write = res_ch.direction_write;
                seen_res.direction_code = res_ch.direction_code;
                if (drive_results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result at cycle %0d: mode %0d speed %0d",
                                 cycle_count, seen_res.motor_mode, seen_res.drive_speed);
                end else begin
                    due_res = drive_results_due.pop_front();
                    bad_fields = "";
                    if (seen_res.motor_mode !== due_res.motor_mode)
                        bad_fields = {bad_fields, " motor_mode"};
                    if (seen_res.drive_speed !== due_res.drive_speed)
                        bad_fields = {bad_fields, " drive_speed"};
                    if (seen_res.speed_write !== due_res.speed_write)
                        bad_fields = {bad_fields, " speed_write"};
                    if (seen_res.direction_write !== due_res.direction_write)
                        bad_fields = {bad_fields, " direction_write"};
                    if (seen_res.direction_code !== due_res.direction_code)
                        bad_fields = {bad_fields, " direction_code"};
                    if (bad_fields != "") begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch at result %0d (%s): expected mode %0d speed %0d sw %0b dw %0b dir %0d",
                                     results_seen, bad_fields, due_res.motor_mode,
                                     due_res.drive_speed, due_res.speed_write,
                                     due_res.direction_write, due_res.direction_code);
                            $display("  got mode %0d speed %0d sw %0b dw %0b dir %0d",
                                     seen_res.motor_mode, seen_res.drive_speed,
                                     seen_res.speed_write, seen_res.direction_write,
                                     seen_res.direction_code);
                        end
                    end
                end
            end
            res_ch.ready <= !(hold_armed && hold_count < HOLD_LEN) &&
                            ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic queue_tick(mds_pkg::t_req r);
        pending_ticks.push_back(r);
        ticks_queued++;
    endtask

    // steady command with random bits that all decode to one mode
    task automatic queue_hold(mds_pkg::t_mode m, int len);
        mds_pkg::t_req r;
        repeat (len) begin
            do r = mds_pkg::t_req'($urandom_range(31)); while (requested_mode(r) != m);
            queue_tick(r);
        end
    endtask

    task automatic queue_random(int n);
        int             count;
        int             len;
        mds_pkg::t_mode m;
        count = 0;
        while (count < n) begin
            if ($urandom_range(99) < 80) begin
                case ($urandom_range(2))
                    0: m = mds_pkg::MODE_IDLE;
                    1: m = mds_pkg::MODE_RIGHT;
                    default: m = mds_pkg::MODE_LEFT;
                endcase
                len = $urandom_range(5, 260);
                if (len > n - count) len = n - count;
                queue_hold(m, len);
            end else begin
                len = $urandom_range(1, 6);
                if (len > n - count) len = n - count;
                repeat (len) queue_tick(mds_pkg::t_req'($urandom_range(31)));
            end
            count += len;
        end
    endtask

    // leaves valid high so back-to-back writes follow each other without valid dropping
    task automatic write_reg(logic [mds_pkg::CFG_IDX_W-1:0] idx,
                             logic [mds_pkg::CFG_DATA_W-1:0] val);
        int unsigned gap;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        reg_writes++;
        case (idx)
            mds_pkg::REG_SPEED_TARGET: reg_target = val;
            mds_pkg::REG_SPEED_SWING: reg_swing = val;
            mds_pkg::REG_STEP_INTERVAL: begin
                gap = val[mds_pkg::INTERVAL_W-1:0];
                if (gap < mds_pkg::INTERVAL_MIN) gap = mds_pkg::INTERVAL_MIN;
                if (gap > mds_pkg::INTERVAL_MAX) gap = mds_pkg::INTERVAL_MAX;
                reg_interval = gap;
            end
            default: ;
        endcase
    endtask

    task automatic set_registers(logic [mds_pkg::CFG_DATA_W-1:0] target,
                                 logic [mds_pkg::CFG_DATA_W-1:0] swing,
                                 logic [mds_pkg::CFG_DATA_W-1:0] interval_raw, int send_pct,
                                 int stall_pct);
        write_reg(mds_pkg::REG_SPEED_TARGET, target);
        write_reg(mds_pkg::REG_SPEED_SWING, swing);
        write_reg(mds_pkg::REG_STEP_INTERVAL, interval_raw);
        cfg_ch.valid <= 1'b0;
        send_idle_pct <= send_pct;
        recv_stall_pct <= stall_pct;
    endtask

    task automatic drain_results();
        while (ticks_taken != ticks_queued || results_seen < ticks_taken) @(posedge i_clk);
    endtask

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.switch_right = 1'b0;
        cmd_ch.switch_left = 1'b0;
        cmd_ch.remote_right = 1'b0;
        cmd_ch.remote_left = 1'b0;
        cmd_ch.remote_stop = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = mds_pkg::REG_SPEED_TARGET;
        cfg_ch.data = '0;
        res_ch.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bit order: switch_right, switch_left, remote_right, remote_left, remote_stop
        queue_tick(mds_pkg::t_req'(5'b00000));
        queue_tick(mds_pkg::t_req'(5'b10000));
        queue_tick(mds_pkg::t_req'(5'b01000));
        queue_tick(mds_pkg::t_req'(5'b00100));
        queue_tick(mds_pkg::t_req'(5'b00010));
        queue_tick(mds_pkg::t_req'(5'b11000));
        queue_tick(mds_pkg::t_req'(5'b00110));
        queue_tick(mds_pkg::t_req'(5'b10010));
        queue_tick(mds_pkg::t_req'(5'b01100));
        queue_tick(mds_pkg::t_req'(5'b01010));
        queue_tick(mds_pkg::t_req'(5'b11111));
        queue_tick(mds_pkg::t_req'(5'b00001));
        queue_tick(mds_pkg::t_req'(5'b10001));
        queue_tick(mds_pkg::t_req'(5'b01011));
        queue_tick(mds_pkg::t_req'(5'b01111));
        queue_tick(mds_pkg::t_req'(5'b10100));
        queue_tick(mds_pkg::t_req'(5'b01010));
        queue_tick(mds_pkg::t_req'(5'b00100));
        queue_tick(mds_pkg::t_req'(5'b00000));
        drain_results();

        // interval below range, receiver held off while the sender keeps offering
        set_registers(15'd1000, 15'd100, 15'd3, 0, 0);
        hold_armed <= 1'b1;
        queue_random(200);
        drain_results();

        // widest band, ends running right after a fresh reload
        set_registers(15'h7FFF, 15'h7FFF, 15'd100, 71, 0);
        queue_random(150);
        queue_hold(mds_pkg::MODE_IDLE, 5);
        queue_hold(mds_pkg::MODE_RIGHT, 150);
        drain_results();

        // band drops below the running speed
        set_registers(15'd0, 15'd8000, 15'd150, 0, 71);
        queue_hold(mds_pkg::MODE_RIGHT, 120);
        queue_random(150);
        drain_results();

        // zero swing, unused register index
        write_reg(REG_UNUSED, 15'h5A5A);
        set_registers(15'd12345, 15'd0, 15'd100, 11, 11);
        queue_random(150);
        drain_results();

        // interval above range, one long run
        set_registers(15'd500, 15'd1, 15'h7FFF, 0, 0);
        queue_hold(mds_pkg::MODE_LEFT, 1010);
        queue_random(20);
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d ticks checked, %0d speed steps, %0d register writes over six settings",
                 ticks_taken, speed_steps, reg_writes);
        $display("%0d mismatches, %0d results still outstanding",
                 mismatches, drive_results_due.size());
        if (mismatches == 0 && drive_results_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ===== motor_direction_speed_dither.f =====
+incdir+rtl/core
rtl/core/mds_pkg.sv
rtl/core/mds_intf.sv
rtl/core/mds_cfg_regs.sv
rtl/core/mds_engine.sv
rtl/core/motor_direction_speed_dither.sv
rtl/core/mds_checker.sv
bench/tb_motor_direction_speed_dither.sv
